[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define WONF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define WONF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/wonf_pkg.sv]
package wonf_pkg;

    // default geometry limits and window radius
    localparam int RADIUS_DEF     = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd35;
    localparam logic [DIM_W-1:0] DIM_RST       = 11'd512;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_idx;

endpackage

[rtl/wonf_ram.sv]
module wonf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port (read returns old data)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/window_outlier_noise_filter_core.sv]
// The result of an accepted item passes stages 1, 2, 3 and 4 and then the output register.
// Throughput: one item per cycle, sustained; the pipeline holds only while a result is stalled.
// Per cycle every window row is read at once from its own copy of the pixel ring memory.
// Reset (synchronous, active low): counters, pipeline valids and registers to defaults;
// the pixel ring is not cleared, entries are written before they are read.
module window_outlier_noise_filter_core #(
    parameter int RADIUS     = wonf_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH  = wonf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wonf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [wonf_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [wonf_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                            o_frame_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wonf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wonf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import wonf_pkg::*;

    localparam int SIDE  = 2 * RADIUS + 1;
    localparam int NB    = SIDE * SIDE - 1;
    localparam int DEPTH = SIDE * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RTW   = $clog2(MAX_HEIGHT + RADIUS + 1);
    localparam int PREW  = $clog2(RADIUS * MAX_WIDTH + 1);
    localparam int RW    = $clog2(RADIUS + 1);
    localparam int KW    = $clog2(SIDE);
    localparam int OFFW  = AW + 2;
    localparam int TW    = RTW + 2;
    localparam int HCW   = RW + 2;
    localparam int CSW   = $clog2(SIDE * 255 + 1);
    localparam int SW    = $clog2(SIDE * SIDE * 255 + 1);
    localparam int NSW   = $clog2(NB * 255 + 1);
    localparam int KSH   = NSW + $clog2(NB);
    localparam longint MUL = ((longint'(1) << KSH) + NB - 1) / NB;
    localparam int MW    = $clog2(MUL + 1);
    localparam int PW    = NSW + MW;
    localparam int CW    = (DIM_W > WW + 1) ? ((DIM_W > HW + 1) ? DIM_W : HW + 1)
                                            : ((WW > HW) ? WW + 1 : HW + 1);

    localparam logic [MW-1:0]          MUL_C   = MW'(MUL);
    localparam logic signed [OFFW-1:0] DEPTH_S = OFFW'(DEPTH);
    localparam logic signed [TW-1:0]   R_T     = TW'(RADIUS);
    localparam logic signed [TW-1:0]   ONE_T   = TW'(1);
    localparam logic signed [HCW-1:0]  R_H     = HCW'(RADIUS);

    // configuration registers
    logic [PIX_W-1:0] r_thr;
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RST;
            r_cfg_w <= DIM_RST;
            r_cfg_h <= DIM_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD:    r_thr   <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // geometry limited to the supported range
    logic [CW-1:0] w_ext, h_ext;
    logic [WW-1:0] w_clamp, w_cur;
    logic [HW-1:0] h_clamp, h_cur;

    always_comb begin
        w_ext = CW'(r_cfg_w);
        h_ext = CW'(r_cfg_h);
        if (w_ext == '0) begin
            w_clamp = WW'(1);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(w_ext);
        end
        if (h_ext == '0) begin
            h_clamp = HW'(1);
        end else if (h_ext > CW'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(h_ext);
        end
    end

    // frame state and counters
    logic                   r_first;
    logic [WW-1:0]          r_w;
    logic [HW-1:0]          r_h;
    logic signed [OFFW-1:0] r_off [SIDE];
    logic [AW-1:0]          r_wa, r_at;
    logic [XW-1:0]          r_xn, r_xt, r_xp;
    logic [HW-1:0]          r_rn, r_rp;
    logic [RTW-1:0]         r_rt;
    logic [PREW-1:0]        r_pre;
    logic [RW-1:0]          r_fill;

    logic            pipe_en, acc, pix_phase, ignore, step, wr, tread, emit, last;
    logic [PREW-1:0] pre_cur;
    logic [RW-1:0]   hlo, hhi;
    logic [WW-1:0]   w_rem;

    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en;
    assign w_cur   = r_first ? w_clamp : r_w;
    assign h_cur   = r_first ? h_clamp : r_h;

    // item classification
    always_comb begin
        acc       = i_valid && pipe_en;
        pix_phase = r_rn < h_cur;
        ignore    = pix_phase && (i_cmd == CMD_FLUSH);
        step      = acc && !ignore;
        wr        = step && pix_phase;
        pre_cur   = r_first ? PREW'(RADIUS * w_cur) : r_pre;
        tread     = step && (pre_cur == '0);
        emit      = tread && (r_fill == RW'(RADIUS));
        last      = emit && (r_rp == HW'(r_h - HW'(1))) && (r_xp == XW'(r_w - WW'(1)));
        hlo       = (r_xp < XW'(RADIUS)) ? RW'(r_xp) : RW'(RADIUS);
        w_rem     = WW'(r_w - WW'(1) - WW'(r_xp));
        hhi       = (w_rem < WW'(RADIUS)) ? RW'(w_rem) : RW'(RADIUS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (last && step)) begin
            r_first <= 1'b1;
            r_wa    <= '0;
            r_at    <= '0;
            r_xn    <= '0;
            r_xt    <= '0;
            r_xp    <= '0;
            r_rn    <= '0;
            r_rt    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
            r_pre   <= '0;
            if (!i_rst_n) begin
                r_w <= WW'(DIM_RST);
                r_h <= HW'(DIM_RST);
            end
        end else if (step) begin
            // geometry taken on the first item of a frame
            if (r_first) begin
                r_first <= 1'b0;
                r_w     <= w_clamp;
                r_h     <= h_clamp;
                for (int k = 0; k < SIDE; k++) begin
                    r_off[k] <= $signed(OFFW'(k) - OFFW'(RADIUS)) * $signed(OFFW'(w_clamp));
                end
            end
            // write side of the ring
            if (wr) begin
                r_wa <= (r_wa == AW'(DEPTH - 1)) ? '0 : AW'(r_wa + AW'(1));
                if (r_xn == XW'(w_cur - WW'(1))) begin
                    r_xn <= '0;
                    r_rn <= HW'(r_rn + HW'(1));
                end else begin
                    r_xn <= XW'(r_xn + XW'(1));
                end
            end
            // column read position
            if (tread) begin
                r_at <= (r_at == AW'(DEPTH - 1)) ? '0 : AW'(r_at + AW'(1));
                if (r_xt == XW'(r_w - WW'(1))) begin
                    r_xt <= '0;
                    r_rt <= RTW'(r_rt + RTW'(1));
                end else begin
                    r_xt <= XW'(r_xt + XW'(1));
                end
                if (r_fill != RW'(RADIUS)) begin
                    r_fill <= RW'(r_fill + RW'(1));
                end
            end else begin
                r_pre <= PREW'(pre_cur - PREW'(1));
            end
            // output position
            if (emit) begin
                if (r_xp == XW'(r_w - WW'(1))) begin
                    r_xp <= '0;
                    r_rp <= HW'(r_rp + HW'(1));
                end else begin
                    r_xp <= XW'(r_xp + XW'(1));
                end
            end
        end
    end

    // read addresses of one column, rows clamped to the frame
    logic [AW-1:0]    raddr [SIDE];
    logic [SIDE-1:0]  fwd;

    always_comb begin
        logic signed [TW-1:0]   lo, hi, jc;
        logic signed [OFFW-1:0] a_sum;
        for (int k = 0; k < SIDE; k++) begin
            lo = (r_rt < RTW'(RADIUS)) ? -$signed(TW'(r_rt)) : -R_T;
            hi = $signed(TW'(r_h)) - ONE_T - $signed(TW'(r_rt));
            if (hi > R_T) begin
                hi = R_T;
            end
            jc = $signed(TW'(k)) - R_T;
            if (jc > hi) begin
                jc = hi;
            end
            if (jc < lo) begin
                jc = lo;
            end
            a_sum = $signed(OFFW'(r_at)) + r_off[KW'(jc + R_T)];
            if (a_sum < 0) begin
                a_sum = a_sum + DEPTH_S;
            end else if (a_sum >= DEPTH_S) begin
                a_sum = a_sum - DEPTH_S;
            end
            raddr[k] = AW'(a_sum);
            fwd[k]   = wr && (raddr[k] == r_wa);
        end
    end

    // one ring copy per window row
    logic [PIX_W-1:0] rdata [SIDE];

    for (genvar g = 0; g < SIDE; g++) begin : g_ring
        wonf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr),
            .i_waddr (r_wa),
            .i_wdata (i_pixel_in),
            .i_re    (pipe_en),
            .i_raddr (raddr[g]),
            .o_rdata (rdata[g])
        );
    end

    // stage 1: memory data, forwarding of the pixel written alongside
    logic             r_p1_tread, r_p1_emit, r_p1_last;
    logic [RW-1:0]    r_p1_hlo, r_p1_hhi;
    logic [SIDE-1:0]  r_p1_fwd;
    logic [PIX_W-1:0] r_p1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tread <= 1'b0;
            r_p1_emit  <= 1'b0;
        end else if (pipe_en) begin
            r_p1_tread <= tread;
            r_p1_emit  <= emit;
        end
        if (pipe_en) begin
            r_p1_last <= last;
            r_p1_hlo  <= hlo;
            r_p1_hhi  <= hhi;
            r_p1_fwd  <= fwd;
            r_p1_pix  <= i_pixel_in;
        end
    end

    logic [CSW-1:0]   col_sum;
    logic [PIX_W-1:0] col_ctr;

    always_comb begin
        logic [PIX_W-1:0] v;
        col_sum = '0;
        col_ctr = '0;
        for (int k = 0; k < SIDE; k++) begin
            v       = r_p1_fwd[k] ? r_p1_pix : rdata[k];
            col_sum = CSW'(col_sum + CSW'(v));
            if (k == RADIUS) begin
                col_ctr = v;
            end
        end
    end

    // stage 2: line of the last column sums and centre-row pixels
    logic [CSW-1:0]   r_line_cs [SIDE];
    logic [PIX_W-1:0] r_line_px [SIDE];
    logic             r_p2_emit, r_p2_last;
    logic [RW-1:0]    r_p2_hlo, r_p2_hhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_emit <= 1'b0;
        end else if (pipe_en) begin
            r_p2_emit <= r_p1_emit;
        end
        if (pipe_en) begin
            r_p2_last <= r_p1_last;
            r_p2_hlo  <= r_p1_hlo;
            r_p2_hhi  <= r_p1_hhi;
            if (r_p1_tread) begin
                for (int k = 0; k < SIDE - 1; k++) begin
                    r_line_cs[k] <= r_line_cs[k+1];
                    r_line_px[k] <= r_line_px[k+1];
                end
                r_line_cs[SIDE-1] <= col_sum;
                r_line_px[SIDE-1] <= col_ctr;
            end
        end
    end

    // window sum with columns clamped to the row
    logic [SW-1:0]  win_sum;
    logic [NSW-1:0] nb_sum;

    always_comb begin
        logic signed [HCW-1:0] jc;
        win_sum = '0;
        for (int k = 0; k < SIDE; k++) begin
            jc = $signed(HCW'(k)) - R_H;
            if (jc > $signed(HCW'(r_p2_hhi))) begin
                jc = $signed(HCW'(r_p2_hhi));
            end
            if (jc < -$signed(HCW'(r_p2_hlo))) begin
                jc = -$signed(HCW'(r_p2_hlo));
            end
            win_sum = SW'(win_sum + SW'(r_line_cs[KW'(jc + R_H)]));
        end
        nb_sum = NSW'(win_sum - SW'(r_line_px[RADIUS]));
    end

    // stage 3: neighbour sum
    logic             r_p3_emit, r_p3_last;
    logic [NSW-1:0]   r_p3_sum;
    logic [PIX_W-1:0] r_p3_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_emit <= 1'b0;
        end else if (pipe_en) begin
            r_p3_emit <= r_p2_emit;
        end
        if (pipe_en) begin
            r_p3_last <= r_p2_last;
            r_p3_sum  <= nb_sum;
            r_p3_ctr  <= r_line_px[RADIUS];
        end
    end

    // stage 4: mean by reciprocal multiply
    logic             r_p4_emit, r_p4_last;
    logic [PW-1:0]    r_p4_prod;
    logic [PIX_W-1:0] r_p4_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_emit <= 1'b0;
        end else if (pipe_en) begin
            r_p4_emit <= r_p3_emit;
        end
        if (pipe_en) begin
            r_p4_last <= r_p3_last;
            r_p4_prod <= PW'(r_p3_sum) * PW'(MUL_C);
            r_p4_ctr  <= r_p3_ctr;
        end
    end

    // decision and output register
    logic [PIX_W-1:0] mean, diff;
    logic             r_out_valid, r_out_last;
    logic [PIX_W-1:0] r_out_pix;

    always_comb begin
        mean = r_p4_prod[KSH +: PIX_W];
        diff = (mean > r_p4_ctr) ? PIX_W'(mean - r_p4_ctr) : PIX_W'(r_p4_ctr - mean);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_p4_emit;
        end
        if (pipe_en) begin
            r_out_last <= r_p4_last;
            r_out_pix  <= (diff <= r_thr) ? r_p4_ctr : mean;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_frame_last = r_out_last;

endmodule

[rtl/wonf_checker.sv]
`include "assert_macros.svh"

module wonf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            i_cmd,
    input logic [wonf_pkg::PIX_W-1:0]      i_pixel_in,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [wonf_pkg::PIX_W-1:0]      o_pixel_out,
    input logic                            o_frame_last
);

    // input held back only by a blocked result
    `WONF_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "input stalled without a blocked result")

    // no result straight after reset
    `WONF_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // a blocked result stays put
    `WONF_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_out) && $stable(o_frame_last)), "blocked result changed")

    // a stalled input item stays put
    `WONF_ASSERT(a_in_hold, i_clk, i_rst_n, (i_valid && o_stall) |=> (i_valid && $stable(i_cmd) && $stable(i_pixel_in)), "stalled item changed")

endmodule

bind window_outlier_noise_filter_core wonf_checker u_wonf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_cmd        (i_cmd),
    .i_pixel_in   (i_pixel_in),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pixel_out  (o_pixel_out),
    .o_frame_last (o_frame_last)
);
